// ===== rtl/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// shared constants for the serial line assembler: sizes, register indexes
// and character codes
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

  localparam int unsigned LineDepth = 64;
  localparam int unsigned AddrW     = $clog2(LineDepth);
  localparam int unsigned CntW      = AddrW;
  localparam int unsigned LimW      = 7;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 6;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIdxW-1:0] CfgEnable    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLineLimit = CfgIdxW'(1);

  localparam logic [ByteW-1:0] ChCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChLf   = 8'h0A;
  localparam logic [ByteW-1:0] ChBs   = 8'h08;
  localparam logic [ByteW-1:0] ChTab  = 8'h09;
  localparam logic [ByteW-1:0] ChLow  = 8'h20;
  localparam logic [ByteW-1:0] ChHigh = 8'h7E;

  localparam logic [LimW-1:0] LimReset = LimW'(LineDepth);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/sla_ram.sv =====
// ----------------------------------------------------------------------------
// sla_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/serial_line_assembler_unit.sv =====
// the first result of a line follows the accepted CR or LF through the
// dump state, the line store read and the output register
// throughput: one input byte per cycle while collecting; in a dump the next
// read waits for the prior byte to load and for the output not to stall;
// input is stalled until the last read of the line has been issued
// reset: line empty, enable set, line limit 64; the line store is not cleared
// ----------------------------------------------------------------------------
// serial_line_assembler_unit
// collects received serial bytes into a command line held in a line store
// and emits the completed line byte by byte on cr or lf
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [sla_pkg::ByteW-1:0]    rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [sla_pkg::ByteW-1:0]    line_byte_o,
  output logic      [sla_pkg::LenW-1:0]     line_length_o,
  output logic                              last_byte_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sla_pkg::CfgDataW-1:0] cfg_data_i
);

  sla_pkg::state_e state_q, state_d;

  logic                       en_q, en_d;
  logic [sla_pkg::LimW-1:0]   lim_q, lim_d;
  logic [sla_pkg::CntW-1:0]   fill_q, fill_d;
  logic [sla_pkg::CntW-1:0]   len_q, len_d;
  logic [sla_pkg::AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic                       rd_pend_q, rd_pend_d;
  logic                       pend_last_q, pend_last_d;
  logic                       out_valid_q, out_valid_d;
  logic [sla_pkg::ByteW-1:0]  out_byte_q, out_byte_d;
  logic [sla_pkg::CntW-1:0]   out_len_q, out_len_d;
  logic                       out_last_q, out_last_d;

  logic                       in_acc;
  logic                       out_acc;
  logic                       cfg_acc;
  logic [sla_pkg::LimW-1:0]   lim_clamp;
  logic [sla_pkg::LimW-1:0]   cap;
  logic                       is_print;
  logic                       is_eol;
  logic                       issue;
  logic                       ram_we;
  logic [sla_pkg::ByteW-1:0]  ram_rdata;

  assign in_stall_o  = (state_q != sla_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // effective line limit, clamped to 1..depth; a line holds at most one byte less
  always_comb begin
    lim_clamp = lim_q;
    if (lim_q == '0) begin
      lim_clamp = sla_pkg::LimW'(1);
    end else if (lim_q > sla_pkg::LimW'(sla_pkg::LineDepth)) begin
      lim_clamp = sla_pkg::LimW'(sla_pkg::LineDepth);
    end
  end
  assign cap = lim_clamp - sla_pkg::LimW'(1);

  assign is_print = (rx_byte_i >= sla_pkg::ChLow) && (rx_byte_i <= sla_pkg::ChHigh);
  assign is_eol   = (rx_byte_i == sla_pkg::ChCr) || (rx_byte_i == sla_pkg::ChLf);
  assign issue    = (state_q == sla_pkg::ST_DUMP) && !rd_pend_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    lim_d       = lim_q;
    fill_d      = fill_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = issue;
    pend_last_d = pend_last_q;
    ram_we      = 1'b0;

    unique case (state_q)
      sla_pkg::ST_IDLE: begin
        if (in_acc && en_q && (fill_q != '0 || is_print)) begin
          priority if (is_eol) begin
            len_d    = fill_q;
            rd_idx_d = '0;
            fill_d   = '0;
            state_d  = sla_pkg::ST_DUMP;
          end else if (rx_byte_i == sla_pkg::ChBs) begin
            if (fill_q != '0) begin
              fill_d = fill_q - sla_pkg::CntW'(1);
            end
          end else if (rx_byte_i == sla_pkg::ChTab) begin
            fill_d = fill_q;
          end else begin
            if (sla_pkg::LimW'(fill_q) < cap) begin
              ram_we = 1'b1;
              fill_d = fill_q + sla_pkg::CntW'(1);
            end
          end
        end
      end
      sla_pkg::ST_DUMP: begin
        if (issue) begin
          pend_last_d = (rd_idx_q == len_q - sla_pkg::CntW'(1));
          rd_idx_d    = rd_idx_q + sla_pkg::AddrW'(1);
          if (pend_last_d) begin
            state_d = sla_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sla_pkg::ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      priority if (cfg_index_i == sla_pkg::CfgEnable) begin
        if (cfg_data_i[0] != en_q) begin
          en_d   = cfg_data_i[0];
          fill_d = '0;
        end
      end else if (cfg_index_i == sla_pkg::CfgLineLimit) begin
        lim_d = cfg_data_i[sla_pkg::LimW-1:0];
      end else begin
        lim_d = lim_q;
      end
    end
  end

  // output register, loaded in the cycle after a read is issued
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_byte_d  = ram_rdata;
      out_len_d   = len_q;
      out_last_d  = pend_last_q;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sla_pkg::ST_IDLE;
      en_q        <= 1'b1;
      lim_q       <= sla_pkg::LimReset;
      fill_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      lim_q       <= lim_d;
      fill_q      <= fill_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    rd_idx_q    <= rd_idx_d;
    pend_last_q <= pend_last_d;
    out_byte_q  <= out_byte_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
  end

  sla_ram #(
    .Width (sla_pkg::ByteW),
    .Depth (sla_pkg::LineDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (rx_byte_i),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign line_byte_o   = out_byte_q;
  assign line_length_o = sla_pkg::LenW'(out_len_q);
  assign last_byte_o   = out_last_q;

  // read data must never land on an occupied output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("line store data arrived while output register busy");

  // the line store is never written during a dump
  a_no_write_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == sla_pkg::ST_IDLE))
    else $error("line store written during dump");

  // a dump always covers a non-empty line
  a_dump_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sla_pkg::ST_DUMP) |-> (len_q != '0))
    else $error("dump of an empty line");

  // issuing the last read ends the dump
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && pend_last_d) |=> (state_q == sla_pkg::ST_IDLE) && out_last_d)
    else $error("dump did not end after last read");

endmodule

`default_nettype wire
